[sv/tac_pkg.sv]
`default_nettype none

package tac_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTOR_RATE  = 2'd0;
  localparam logic [1:0] CFG_CRITIC_RATE = 2'd1;
  localparam logic [1:0] CFG_DISCOUNT    = 2'd2;

  localparam logic [15:0] ACTOR_RATE_RST  = 16'd6554;
  localparam logic [15:0] CRITIC_RATE_RST = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST    = 16'd64881;

  // step strobes shared by the critic and the actor lanes
  typedef struct packed {
    logic clr;   // clearing pass: write zero
    logic rd;    // read the tables
    logic mul;   // first multiply
    logic td;    // round and add
    logic mul2;  // second multiply
    logic wr;    // commit
  } tac_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
    logic signed [15:0] r;
    if (x > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/tac_lane.sv]
`default_nettype none

module tac_lane #(
  parameter int NUM_STATES = 256,
  parameter int SW         = 8
) (
  input  wire                      clk,
  input  tac_pkg::tac_ctl_t        ctl,
  input  wire  [SW-1:0]            rd_addr,
  input  wire  [SW-1:0]            wr_addr,
  input  wire  [15:0]              rate,
  input  wire  signed [15:0]       goal,
  output logic signed [15:0]       cur,
  output logic signed [15:0]       upd_val
);
  import tac_pkg::*;

  logic signed [15:0] mem [NUM_STATES];
  logic signed [15:0] cur_r;
  logic signed [33:0] prod_r;
  logic signed [15:0] new_r;

  logic signed [16:0] diff;
  logic signed [33:0] prod_nxt;
  logic signed [33:0] prod_sum;
  logic signed [17:0] prod_rnd;
  logic signed [23:0] new_full;

  assign diff     = 17'(goal) - 17'(cur_r);
  assign prod_nxt = 34'($signed({1'b0, rate})) * 34'(diff);
  assign prod_sum = prod_r + 34'sd32768;
  assign prod_rnd = $signed(prod_sum[33:16]);
  assign new_full = 24'(cur_r) + 24'(prod_rnd);

  always_ff @(posedge clk) begin
    if (ctl.clr || ctl.wr) begin
      mem[wr_addr] <= ctl.clr ? 16'sd0 : new_r;
    end
    if (ctl.rd) begin
      cur_r <= mem[rd_addr];
    end
    if (ctl.mul) begin
      prod_r <= prod_nxt;
    end
    if (ctl.td) begin
      new_r <= sat16(new_full);
    end
  end

  assign cur     = cur_r;
  assign upd_val = new_r;

endmodule

`default_nettype wire

[sv/tac_critic.sv]
`default_nettype none

module tac_critic #(
  parameter int NUM_STATES = 256,
  parameter int SW         = 8
) (
  input  wire                      clk,
  input  tac_pkg::tac_ctl_t        ctl,
  input  wire  [SW-1:0]            rd_st,
  input  wire  [SW-1:0]            rd_nx,
  input  wire  [SW-1:0]            wr_addr,
  input  wire  signed [15:0]       reward,
  input  wire                      terminal,
  input  wire  [15:0]              discount,
  input  wire  [15:0]              critic_rate,
  output logic signed [15:0]       old_v,
  output logic signed [15:0]       new_v,
  output logic                     raise
);
  import tac_pkg::*;

  logic signed [15:0] mem [NUM_STATES];
  logic signed [15:0] v_old_r;
  logic signed [15:0] v_nx_r;
  logic signed [32:0] boot_prod_r;
  logic signed [18:0] td_r;
  logic signed [35:0] crit_prod_r;

  logic signed [32:0] boot_prod_nxt;
  logic signed [32:0] boot_sum;
  logic signed [16:0] boot_rnd;
  logic signed [18:0] target;
  logic signed [18:0] td_nxt;
  logic signed [35:0] crit_prod_nxt;
  logic signed [35:0] crit_sum;
  logic signed [19:0] crit_rnd;
  logic signed [23:0] new_full;

  assign boot_prod_nxt = 33'($signed({1'b0, discount})) * 33'(v_nx_r);
  assign boot_sum      = boot_prod_r + 33'sd32768;
  assign boot_rnd      = $signed(boot_sum[32:16]);
  assign target        = terminal ? 19'(reward) : 19'(reward) + 19'(boot_rnd);
  assign td_nxt        = target - 19'(v_old_r);
  assign crit_prod_nxt = 36'($signed({1'b0, critic_rate})) * 36'(td_r);
  assign crit_sum      = crit_prod_r + 36'sd32768;
  assign crit_rnd      = $signed(crit_sum[35:16]);
  assign new_full      = 24'(v_old_r) + 24'(crit_rnd);

  always_ff @(posedge clk) begin
    if (ctl.clr || ctl.wr) begin
      mem[wr_addr] <= ctl.clr ? 16'sd0 : new_v;
    end
    // both reads see the table before this item's write
    if (ctl.rd) begin
      v_old_r <= mem[rd_st];
      v_nx_r  <= mem[rd_nx];
    end
    if (ctl.mul) begin
      boot_prod_r <= boot_prod_nxt;
    end
    if (ctl.td) begin
      td_r <= td_nxt;
    end
    if (ctl.mul2) begin
      crit_prod_r <= crit_prod_nxt;
    end
  end

  assign old_v = v_old_r;
  assign new_v = sat16(new_full);
  assign raise = new_v > v_old_r;

endmodule

`default_nettype wire

[sv/tabular_actor_critic_update.sv]
`default_nettype none
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   tdata 96b, tuser mode, tlast end_of_episode
// out_     master     out_tvalid / out_tready tdata 80b, tuser actor_updated
// cfg_     slave      cfg_valid / cfg_ready   cfg_index 2b, cfg_data 16b
// Each item steps through accept with table read, bootstrap multiply, round and
// TD error, critic multiply and write back; the next item is accepted after write back.
// After reset a clearing pass zeroes every entry of both tables; no word is
// accepted meanwhile. A result waits in the output register; the next word is taken
// while it waits, and write back stalls only if the previous result is still held.

module tabular_actor_critic_update #(
  parameter int NUM_STATES = 256,
  parameter int ACTION_DIM = 4
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  // [7:0] state_index, [15:8] next_state_index, [31:16] reward,
  // [47:32] taken_0, [63:48] taken_1, [79:64] taken_2, [95:80] taken_3
  input  wire  [95:0]  in_tdata,
  input  wire          in_tuser,   // mode
  input  wire          in_tlast,   // end_of_episode
  output logic         out_tvalid,
  input  wire          out_tready,
  // [15:0] greedy_0, [31:16] greedy_1, [47:32] greedy_2, [63:48] greedy_3,
  // [79:64] state_value
  output logic [79:0]  out_tdata,
  output logic         out_tuser,  // actor_updated
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [1:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);
  import tac_pkg::*;

  localparam int SW = $clog2(NUM_STATES);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_TD   = 3'd3;
  localparam logic [2:0] ST_MUL2 = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0] st_r;
  logic          upd_r;
  logic          term_r;
  logic signed [15:0] reward_r;
  logic signed [15:0] goal_r [ACTION_DIM];
  logic [15:0]   actor_rate_r, critic_rate_r, discount_r;
  logic          out_valid_r, out_valid_nxt;
  logic [79:0]   out_data_r;
  logic          out_user_r;

  logic [SW-1:0] st_mod [256];
  logic [SW-1:0] in_st, in_nx, wr_addr;
  logic          accept, wb_go;
  tac_ctl_t      crit_ctl, lane_ctl;

  logic signed [15:0] old_v, new_v;
  logic               raise, moved;
  logic signed [15:0] lane_cur [ACTION_DIM];
  logic signed [15:0] lane_new [ACTION_DIM];
  logic [15:0]        greedy [4];
  logic [15:0]        value_out;

  // state index modulo NUM_STATES, a constant table over the 8-bit field
  for (genvar i = 0; i < 256; i++) begin : g_mod
    assign st_mod[i] = SW'(i % NUM_STATES);
  end

  assign in_st     = st_mod[in_tdata[7:0]];
  assign in_nx     = st_mod[in_tdata[15:8]];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign wb_go     = (state_r == ST_WB) && (!out_valid_r || out_tready);
  assign moved     = upd_r && raise;
  assign wr_addr   = (state_r == ST_CLR) ? clr_cnt_r : st_r;
  assign cfg_ready = 1'b1;
  assign value_out = upd_r ? new_v : old_v;

  always_comb begin
    crit_ctl.clr  = (state_r == ST_CLR);
    crit_ctl.rd   = accept;
    crit_ctl.mul  = (state_r == ST_MUL);
    crit_ctl.td   = (state_r == ST_TD);
    crit_ctl.mul2 = (state_r == ST_MUL2);
    crit_ctl.wr   = wb_go && upd_r;
    lane_ctl      = crit_ctl;
    lane_ctl.wr   = wb_go && moved;
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + SW'(1);
        if (clr_cnt_r == SW'(NUM_STATES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_TD;
      ST_TD:   state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_WB;
      ST_WB: begin
        if (wb_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wb_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      actor_rate_r  <= ACTOR_RATE_RST;
      critic_rate_r <= CRITIC_RATE_RST;
      discount_r    <= DISCOUNT_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ACTOR_RATE:  actor_rate_r  <= cfg_data;
          CFG_CRITIC_RATE: critic_rate_r <= cfg_data;
          CFG_DISCOUNT:    discount_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r     <= in_st;
      upd_r    <= in_tuser;
      term_r   <= in_tlast;
      reward_r <= $signed(in_tdata[31:16]);
    end
    if (wb_go) begin
      out_data_r <= {value_out, greedy[3], greedy[2], greedy[1], greedy[0]};
      out_user_r <= moved;
    end
  end

  tac_critic #(
    .NUM_STATES (NUM_STATES),
    .SW         (SW)
  ) u_critic (
    .clk         (clk),
    .ctl         (crit_ctl),
    .rd_st       (in_st),
    .rd_nx       (in_nx),
    .wr_addr     (wr_addr),
    .reward      (reward_r),
    .terminal    (term_r),
    .discount    (discount_r),
    .critic_rate (critic_rate_r),
    .old_v       (old_v),
    .new_v       (new_v),
    .raise       (raise)
  );

  for (genvar g = 0; g < ACTION_DIM; g++) begin : g_lane
    always_ff @(posedge clk) begin
      if (accept) begin
        goal_r[g] <= $signed(in_tdata[32+16*g +: 16]);
      end
    end

    tac_lane #(
      .NUM_STATES (NUM_STATES),
      .SW         (SW)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .rd_addr (in_st),
      .wr_addr (wr_addr),
      .rate    (actor_rate_r),
      .goal    (goal_r[g]),
      .cur     (lane_cur[g]),
      .upd_val (lane_new[g])
    );
  end

  // merge lane results: moved components show the new value
  for (genvar g = 0; g < 4; g++) begin : g_merge
    if (g < ACTION_DIM) begin : g_used
      assign greedy[g] = moved ? lane_new[g] : lane_cur[g];
    end else begin : g_unused
      assign greedy[g] = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB) && out_valid_r && !out_tready |=> (state_r == ST_WB))
    else $error("write back left while result still held");

  a_clr_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_tready)
    else $error("input ready during clearing pass");

  a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (crit_ctl.wr || lane_ctl.wr) |-> upd_r && (state_r == ST_WB))
    else $error("table write outside an update write back");

  a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_WB)
    else $error("result raised without write back");

endmodule

`default_nettype wire

[sim/tabular_actor_critic_update_tb.sv]
`timescale 1ns / 100ps

module tabular_actor_critic_update_tb;
  import tac_pkg::*;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;
  localparam int   DRAIN_CYCLES = 16;
  localparam int   PRESSURE_AT  = 1450;  // result count where the long hold-off starts
  localparam int   PRESSURE_LEN = 300;

  typedef struct packed {
    logic        mode;
    logic        eoe;
    logic [63:0] taken;   // component a at [16a+15:16a]
    logic [15:0] reward;
    logic [7:0]  nx;
    logic [7:0]  st;
  } step_t;

  typedef struct packed {
    logic        moved;
    logic [15:0] value;
    logic [63:0] greedy;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [79:0] out_tdata;
  wire         out_tuser;
  logic        cfg_valid = 1'b0;
  wire         cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // learner mirror: rates, critic and actor tables
  logic [15:0]        actor_rate_q  = ACTOR_RATE_RST;
  logic [15:0]        critic_rate_q = CRITIC_RATE_RST;
  logic [15:0]        discount_q    = DISCOUNT_RST;
  logic signed [15:0] critic_v [256];
  logic signed [15:0] actor_v  [256][4];

  step_t   pending_steps[$];
  result_t expected_results[$];
  step_t   in_hold;
  int      n_queued = 0;
  int      n_accepted = 0;
  int      n_results = 0;
  int      errors = 0;
  bit      idle_en = 1'b1;
  int      gap_left = 0;
  int      hold_left = 0;

  tabular_actor_critic_update u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // round to nearest, halves up, of x / 2^16
  function automatic longint round_q16(input longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint x);
    if (x > 64'sd32767) return 16'sh7FFF;
    if (x < -64'sd32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic result_t learn_step(input step_t it);
    result_t r;
    longint  old_v, target, new_v, cur, goal;
    int      s, n;
    s = it.st;
    n = it.nx;
    r.moved = 1'b0;
    if (it.mode == MODE_UPDATE) begin
      old_v  = longint'(critic_v[s]);
      target = longint'($signed(it.reward));
      // read the successor before the write: same-state steps bootstrap the old value
      if (!it.eoe) target += round_q16(longint'(discount_q) * longint'(critic_v[n]));
      new_v = longint'(clamp16(old_v + round_q16(longint'(critic_rate_q) * (target - old_v))));
      critic_v[s] = new_v[15:0];
      if (new_v > old_v) begin
        r.moved = 1'b1;
        for (int a = 0; a < 4; a++) begin
          cur  = longint'(actor_v[s][a]);
          goal = longint'($signed(it.taken[16*a +: 16]));
          actor_v[s][a] = clamp16(cur + round_q16(longint'(actor_rate_q) * (goal - cur)));
        end
      end
    end
    for (int a = 0; a < 4; a++) r.greedy[16*a +: 16] = actor_v[s][a];
    r.value = critic_v[s];
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin : drv
    step_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(learn_step(in_hold));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_steps.size() > 0) begin
          s = pending_steps.pop_front();
          in_hold   = s;
          in_tdata  <= {s.taken, s.reward, s.nx, s.st};
          in_tuser  <= s.mode;
          in_tlast  <= s.eoe;
          in_tvalid <= 1'b1;
          gap_left  = idle_en ? $urandom_range(3, 0) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : mon
    result_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result word with no step pending");
          errors++;
        end else begin
          e = expected_results.pop_front();
          for (int a = 0; a < 4; a++) begin
            if (out_tdata[16*a +: 16] !== e.greedy[16*a +: 16]) begin
              $error("greedy_%0d: expected %0d, got %0d", a,
                     $signed(e.greedy[16*a +: 16]), $signed(out_tdata[16*a +: 16]));
              errors++;
            end
          end
          if (out_tdata[79:64] !== e.value) begin
            $error("state_value: expected %0d, got %0d",
                   $signed(e.value), $signed(out_tdata[79:64]));
            errors++;
          end
          if (out_tuser !== e.moved) begin
            $error("actor_updated: expected %0d, got %0d", e.moved, out_tuser);
            errors++;
          end
        end
        if (n_results == PRESSURE_AT) hold_left = PRESSURE_LEN;
        else hold_left = idle_en ? $urandom_range(3, 0) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_step(input step_t s);
    pending_steps.push_back(s);
    n_queued++;
  endtask

  task automatic queue_dir(input logic mode, input logic [7:0] st, input logic [7:0] nx,
                           input logic [15:0] reward, input logic eoe, input logic [63:0] taken);
    step_t s;
    s.mode = mode;
    s.st = st;
    s.nx = nx;
    s.reward = reward;
    s.eoe = eoe;
    s.taken = taken;
    queue_step(s);
  endtask

  // bias toward a few hot states so values build up and saturate
  function automatic logic [7:0] pick_state();
    return ($urandom_range(3, 0) != 0) ? 8'($urandom_range(7, 0)) : 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [15:0] pick_val();
    case ($urandom_range(7, 0))
      0, 1:    return 16'($urandom);
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return 16'($urandom_range(1023, 0) - 512);
    endcase
  endfunction

  // mostly episodes chained through next_state_index, with queries and noise mixed in
  task automatic queue_random(input int count);
    step_t s;
    int    left, len, cur_st;
    logic [7:0] nxt;
    left = count;
    while (left > 0) begin
      if ($urandom_range(9, 0) < 2) begin
        s.mode = 1'($urandom);
        s.eoe = 1'($urandom);
        s.st = 8'($urandom);
        s.nx = 8'($urandom);
        s.reward = 16'($urandom);
        s.taken = {$urandom, $urandom};
        queue_step(s);
        left--;
      end else begin
        len = $urandom_range(8, 1);
        cur_st = pick_state();
        for (int i = 0; i < len && left > 0; i++) begin
          nxt = ($urandom_range(7, 0) == 0) ? 8'(cur_st) : pick_state();
          s.mode = MODE_UPDATE;
          s.st = 8'(cur_st);
          s.nx = nxt;
          s.reward = pick_val();
          s.eoe = (i == len - 1);
          s.taken = {pick_val(), pick_val(), pick_val(), pick_val()};
          queue_step(s);
          left--;
          if ($urandom_range(3, 0) == 0 && left > 0) begin
            s.mode = MODE_QUERY;
            s.nx = 8'($urandom);
            s.reward = 16'($urandom);
            s.eoe = 1'($urandom);
            s.taken = {$urandom, $urandom};
            queue_step(s);
            left--;
          end
          cur_st = nxt;
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ACTOR_RATE:  actor_rate_q = val;
      CFG_CRITIC_RATE: critic_rate_q = val;
      CFG_DISCOUNT:    discount_q = val;
      default: ;
    endcase
  endtask

  task automatic write_rates(input logic [15:0] ar, input logic [15:0] cr,
                             input logic [15:0] dc);
    wait_drained();
    write_reg(CFG_ACTOR_RATE, ar);
    write_reg(CFG_CRITIC_RATE, cr);
    write_reg(CFG_DISCOUNT, dc);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) begin
      critic_v[i] = '0;
      for (int a = 0; a < 4; a++) actor_v[i][a] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: cleared tables, extremes, terminal and bootstrapped steps, self loop
    queue_dir(MODE_QUERY,  8'd0,   8'd0,   16'h0000, 1'b0, 64'h0);
    queue_dir(MODE_QUERY,  8'd255, 8'd255, 16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_dir(MODE_UPDATE, 8'd5,   8'd5,   16'h7FFF, 1'b0, 64'h7FFF_7FFF_7FFF_7FFF);
    queue_dir(MODE_UPDATE, 8'd5,   8'd5,   16'h7FFF, 1'b0, 64'h7FFF_7FFF_7FFF_7FFF);
    queue_dir(MODE_UPDATE, 8'd5,   8'd9,   16'h7FFF, 1'b1, 64'h8000_8000_8000_8000);
    queue_dir(MODE_UPDATE, 8'd5,   8'd9,   16'h8000, 1'b1, 64'h8000_8000_8000_8000);
    queue_dir(MODE_UPDATE, 8'd255, 8'd0,   16'h0000, 1'b1, 64'h1234_5678_9ABC_DEF0);
    queue_dir(MODE_UPDATE, 8'd0,   8'd5,   16'h0100, 1'b0, 64'h7FFF_8000_0000_FFFF);
    queue_dir(MODE_UPDATE, 8'd200, 8'd5,   16'hFFFF, 1'b0, 64'h0100_FF00_0080_FF80);
    queue_dir(MODE_UPDATE, 8'd255, 8'd255, 16'h7FFF, 1'b0, 64'h8000_7FFF_8000_7FFF);
    queue_dir(MODE_UPDATE, 8'd255, 8'd255, 16'h7FFF, 1'b0, 64'h8000_7FFF_8000_7FFF);
    queue_dir(MODE_UPDATE, 8'd1,   8'd255, 16'h8000, 1'b0, 64'h0);
    queue_dir(MODE_UPDATE, 8'd1,   8'd255, 16'h8000, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_dir(MODE_QUERY,  8'd5,   8'd0,   16'h7FFF, 1'b1, 64'h7FFF_7FFF_7FFF_7FFF);
    queue_dir(MODE_QUERY,  8'd255, 8'd1,   16'h8000, 1'b0, 64'h8000_8000_8000_8000);
    queue_dir(MODE_QUERY,  8'd1,   8'd0,   16'h0000, 1'b0, 64'h0);
    queue_random(300);

    write_rates(16'hFFFF, 16'hFFFF, 16'hFFFF);
    idle_en = 1'b0;
    queue_dir(MODE_UPDATE, 8'd5, 8'd5, 16'h7FFF, 1'b0, 64'h7FFF_8000_7FFF_8000);
    queue_dir(MODE_UPDATE, 8'd5, 8'd5, 16'h7FFF, 1'b0, 64'h7FFF_8000_7FFF_8000);
    queue_dir(MODE_UPDATE, 8'd1, 8'd1, 16'h8000, 1'b0, 64'h8000_7FFF_8000_7FFF);
    queue_random(300);

    write_rates(16'h0000, 16'h0000, 16'h0000);
    idle_en = 1'b1;
    queue_random(150);

    write_rates(16'hFFFF, 16'h8000, 16'h0000);
    queue_random(250);

    write_rates(16'($urandom), 16'($urandom), 16'($urandom));
    queue_random(300);

    // back to the power-up rates; the long output hold-off lands in this phase
    write_rates(ACTOR_RATE_RST, CRITIC_RATE_RST, DISCOUNT_RST);
    queue_random(300);

    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
